// File: hw/rtl/gps_pkg.sv
// shared types, status codes and defaults for the prime split core
`default_nettype none
package gps_pkg;

	// default width of the number word
	localparam int NUMBER_WIDTH_DEF = 16;

	// result status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_SMALL   = 2'd1;
	localparam logic [1:0] STATUS_ODD     = 2'd2;
	localparam logic [1:0] STATUS_NOSPLIT = 2'd3;

	// commands from controller to datapath
	typedef struct packed {
		logic       load_n;        // capture the input number
		logic       first_cand;    // first candidate p = 3
		logic       next_cand;     // p += 2
		logic       test_p;        // start primality test of p
		logic       test_partner;  // start primality test of n - p
		logic       div_start;     // clear remainder, load dividend
		logic       div_step;      // one restoring division bit
		logic       next_div;      // d += 2, square updated
		logic       res_load;      // capture result word
		logic [1:0] res_code;      // status of the result word
	} gps_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic le_four;   // n is four or less
		logic odd;       // n is odd
		logic p_over;    // candidate beyond n / 2
		logic sq_over;   // d * d beyond tested value
		logic div_last;  // last division bit in progress
		logic rem_zero;  // remainder is zero
	} gps_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/goldbach_prime_split_core.sv
// top level: splits an even number into the two primes of its smallest split
//
// Usage: drive number and pulse start while busy is low; the word is taken
// at that clock edge and busy rises. One result word follows per input word:
// status, smaller_prime and larger_prime are valid while done is high and
// hold until the next result word. Status 0 is a split, 1 a number of four or less,
// 2 an odd number, 3 no split found; the primes are zero unless status is 0.
// A new word may be started in the cycle that done is high.
//
// Sequence, from the cycle start is taken to the cycle done is high: errors
// are reported after classification. A search steps through each candidate
// p (odd, from 3 up) and, for each primality test (p, then n - p when p is
// prime), through each trial divisor d (odd d from 3 while d * d <= value),
// with one restoring division of the value by d. The bit-serial remainder
// unit takes one quotient bit per cycle, so the search time grows with the
// smallest split.
//
// Reset: arst_n clears the controller to idle with done low; no result is
// pending afterwards. The receiver cannot stall: done is a one-cycle strobe.
`default_nettype none
module goldbach_prime_split_core #(
	parameter int NUMBER_WIDTH = gps_pkg::NUMBER_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [NUMBER_WIDTH-1:0] number,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [NUMBER_WIDTH-1:0]      smaller_prime,
	output logic [NUMBER_WIDTH-1:0]      larger_prime
);
	import gps_pkg::*;

	gps_cmd_t  cmd;
	gps_stat_t stat;

	// sequencer
	gps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// search datapath
	gps_dp #(
		.NUMBER_WIDTH (NUMBER_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.number        (number),
		.cmd           (cmd),
		.stat          (stat),
		.status        (status),
		.smaller_prime (smaller_prime),
		.larger_prime  (larger_prime)
	);

endmodule
`default_nettype wire

// File: hw/rtl/gps_dp.sv
// datapath: candidate, trial divisor, divisor square and bit-serial remainder unit
`default_nettype none
module gps_dp #(
	parameter int NUMBER_WIDTH = gps_pkg::NUMBER_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [NUMBER_WIDTH-1:0] number,
	input  wire gps_pkg::gps_cmd_t       cmd,
	output gps_pkg::gps_stat_t           stat,
	output logic [1:0]                   status,
	output logic [NUMBER_WIDTH-1:0]      smaller_prime,
	output logic [NUMBER_WIDTH-1:0]      larger_prime
);
	import gps_pkg::*;

	localparam int W  = NUMBER_WIDTH;
	localparam int CW = $clog2(W + 1);
	localparam logic [W-1:0]  FOUR     = W'(4);
	localparam logic [W-1:0]  THREE    = W'(3);
	localparam logic [W+1:0]  NINE     = (W + 2)'(9);
	localparam logic [W+1:0]  SQ_INC   = (W + 2)'(4);
	localparam logic [CW-1:0] DIV_BITS = CW'(W);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);

	logic [W-1:0]  n_q;
	logic [W-1:0]  p_q;
	logic [W-1:0]  x_q;
	logic [W-1:0]  d_q;
	logic [W+1:0]  sq_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvd_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]    status_q;
	logic [W-1:0]  small_q;
	logic [W-1:0]  large_q;

	logic [W-1:0] partner;
	logic [W:0]   trial;
	logic [W:0]   trial_diff;
	logic         trial_ge;

	// partner of the candidate and one restoring division bit
	assign partner    = n_q - p_q;
	assign trial      = {rem_q, dvd_q[W-1]};
	assign trial_diff = trial - {1'b0, d_q};
	assign trial_ge   = trial >= {1'b0, d_q};

	// status toward the controller
	assign stat.le_four  = n_q <= FOUR;
	assign stat.odd      = n_q[0];
	assign stat.p_over   = p_q > (n_q >> 1);
	assign stat.sq_over  = sq_q > {2'b00, x_q};
	assign stat.div_last = cnt_q == CNT_ONE;
	assign stat.rem_zero = rem_q == '0;

	// number and candidate
	always_ff @(posedge clk) begin
		if (cmd.load_n) begin
			n_q <= number;
		end
		if (cmd.first_cand) begin
			p_q <= THREE;
		end else if (cmd.next_cand) begin
			p_q <= p_q + W'(2);
		end
	end

	// tested value, trial divisor and its square
	always_ff @(posedge clk) begin
		if (cmd.test_p || cmd.test_partner) begin
			x_q  <= cmd.test_p ? p_q : partner;
			d_q  <= THREE;
			sq_q <= NINE;
		end else if (cmd.next_div) begin
			d_q  <= d_q + W'(2);
			sq_q <= sq_q + {2'b00, d_q} + {2'b00, d_q} + {2'b00, d_q} + {2'b00, d_q}
				+ SQ_INC;
		end
	end

	// bit-serial remainder of x by d
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= DIV_BITS;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - CNT_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			dvd_q <= x_q;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? trial_diff[W-1:0] : trial[W-1:0];
			dvd_q <= dvd_q << 1;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q <= cmd.res_code;
			if (cmd.res_code == STATUS_OK) begin
				small_q <= p_q;
				large_q <= partner;
			end else begin
				small_q <= '0;
				large_q <= '0;
			end
		end
	end

	assign status        = status_q;
	assign smaller_prime = small_q;
	assign larger_prime  = large_q;

	// remainder stays below the divisor while dividing
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.div_step) |-> rem_q < d_q)
		else $error("remainder not below divisor");

	// a split adds back up to the number
	a_split_sum: assert property (@(posedge clk) disable iff (!arst_n)
		($past(cmd.res_load) && status_q == STATUS_OK) |->
		({1'b0, small_q} + {1'b0, large_q}) == {1'b0, n_q})
		else $error("split does not add up to number");

	// the trial divisor is always odd and at least three
	a_div_odd: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.test_p || cmd.test_partner || cmd.next_div) |-> (d_q[0] && d_q >= THREE))
		else $error("trial divisor not odd");

endmodule
`default_nettype wire

// File: hw/rtl/gps_ctrl.sv
// controller: sequences classification, candidate search and trial division
`default_nettype none
module gps_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire gps_pkg::gps_stat_t stat,
	output gps_pkg::gps_cmd_t       cmd,
	output logic                    busy,
	output logic                    done
);
	import gps_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_CLASSIFY = 6'b000010,
		ST_CAND     = 6'b000100,
		ST_CHK      = 6'b001000,
		ST_DIV      = 6'b010000,
		ST_DIVEND   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   partner_q, partner_d;
	logic   done_q;

	// next state and commands
	always_comb begin
		state_d   = state_q;
		partner_d = partner_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load_n = 1'b1;
					state_d    = ST_CLASSIFY;
				end
			end
			ST_CLASSIFY: begin
				priority if (stat.le_four) begin
					cmd.res_load = 1'b1;
					cmd.res_code = STATUS_SMALL;
					state_d      = ST_IDLE;
				end else if (stat.odd) begin
					cmd.res_load = 1'b1;
					cmd.res_code = STATUS_ODD;
					state_d      = ST_IDLE;
				end else begin
					cmd.first_cand = 1'b1;
					state_d        = ST_CAND;
				end
			end
			ST_CAND: begin
				if (stat.p_over) begin
					cmd.res_load = 1'b1;
					cmd.res_code = STATUS_NOSPLIT;
					state_d      = ST_IDLE;
				end else begin
					cmd.test_p = 1'b1;
					partner_d  = 1'b0;
					state_d    = ST_CHK;
				end
			end
			ST_CHK: begin
				if (stat.sq_over) begin
					// no divisor found: value is prime
					if (partner_q) begin
						cmd.res_load = 1'b1;
						cmd.res_code = STATUS_OK;
						state_d      = ST_IDLE;
					end else begin
						cmd.test_partner = 1'b1;
						partner_d        = 1'b1;
					end
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_DIVEND;
				end
			end
			ST_DIVEND: begin
				if (stat.rem_zero) begin
					cmd.next_cand = 1'b1;
					state_d       = ST_CAND;
				end else begin
					cmd.next_div = 1'b1;
					state_d      = ST_CHK;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			partner_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			partner_q <= partner_d;
			done_q    <= cmd.res_load;
		end
	end

	assign busy = state_q != ST_IDLE;
	assign done = done_q;

	// an accepted word makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("start accepted but not busy");

	// a result follows a finished search
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) && !busy))
		else $error("result without search");

	// a division start enters the divide state
	a_div_start_chk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (state_q == ST_DIV))
		else $error("division start lost");

endmodule
`default_nettype wire
